>>> sv/isoep_pkg.sv
package isoep_pkg;

   // Characters that the parser tells apart.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_Z     = 8'h5A;

   localparam logic [3:0] YEAR_DIGITS  = 4'd4;
   localparam logic [3:0] FIELD_DIGITS = 4'd2;
   localparam logic [3:0] FRAC_DIGITS  = 4'd9;

   localparam logic [13:0] YEAR_MAX = 14'd9999;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef logic [QUEUE_AW-1:0] qptr_type;
   typedef logic [QUEUE_AW:0]   qcnt_type;

   typedef enum logic [2:0] {
      PH_YEAR,
      PH_MONTH,
      PH_DAY,
      PH_HOUR,
      PH_MINUTE,
      PH_SECOND,
      PH_FRAC,
      PH_ZSEEN
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  count;
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic        err;
      logic        ended;
   } parse_type;

   // One finished text, as handed from the parser to the date arithmetic.
   typedef struct packed {
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic        err;
      logic        ended;
   } rec_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_LEAP0,
      B_LEAP1,
      B_CHECK,
      B_ERA,
      B_YOE,
      B_DOE,
      B_DAYS,
      B_HRS,
      B_MIN,
      B_MS,
      B_OUT
   } back_state_type;

   // Length of a month; the month is known to lie in 1..12 where it matters.
   function automatic logic [4:0] month_days(logic [6:0] month, logic leap);
      logic [4:0] len;
      unique case (month[3:0])
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // Days before the first of a month, counted in a year that starts in March.
   function automatic logic [8:0] doy_base(logic [3:0] mp);
      logic [8:0] base;
      unique case (mp)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd61;
         4'd3:    base = 9'd92;
         4'd4:    base = 9'd122;
         4'd5:    base = 9'd153;
         4'd6:    base = 9'd184;
         4'd7:    base = 9'd214;
         4'd8:    base = 9'd245;
         4'd9:    base = 9'd275;
         4'd10:   base = 9'd306;
         4'd11:   base = 9'd337;
         default: base = 9'd0;
      endcase
      return base;
   endfunction

endpackage

>>> sv/isoep_front.sv
module isoep_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // char_byte[7:0]
   input  logic                req_tlast,   // last_char
   input  logic                q_full,
   output logic                q_push,
   output isoep_pkg::rec_type  q_rec
);

   isoep_pkg::parse_type state_ff;
   isoep_pkg::parse_type state_in;
   isoep_pkg::parse_type after_char;
   isoep_pkg::parse_type after_end;
   logic                 accept;

   function automatic logic [6:0] mul10(logic [6:0] v, logic [3:0] dv);
      return 7'(v * 7'd10 + 7'(dv));
   endfunction

   function automatic isoep_pkg::parse_type closing(isoep_pkg::parse_type p, logic [7:0] c);
      isoep_pkg::parse_type q;
      q = p;
      if (c == isoep_pkg::CHAR_Z) begin
         q.phase = isoep_pkg::PH_ZSEEN;
         q.count = 4'd0;
      end else if (c == isoep_pkg::CHAR_NUL) begin
         q.ended = 1'b1;
      end else begin
         q.err = 1'b1;
      end
      return q;
   endfunction

   function automatic isoep_pkg::parse_type feed(isoep_pkg::parse_type p, logic [7:0] c);
      isoep_pkg::parse_type q;
      logic                 dig;
      logic [3:0]           dv;
      logic [3:0]           maxd;
      q    = p;
      dig  = (c >= isoep_pkg::CHAR_0) && (c <= isoep_pkg::CHAR_9);
      dv   = c[3:0];
      maxd = isoep_pkg::FIELD_DIGITS;
      if (p.phase == isoep_pkg::PH_YEAR) begin
         maxd = isoep_pkg::YEAR_DIGITS;
      end else if (p.phase == isoep_pkg::PH_FRAC) begin
         maxd = isoep_pkg::FRAC_DIGITS;
      end
      if (!(p.err || p.ended)) begin
         if (dig && p.phase != isoep_pkg::PH_ZSEEN) begin
            if (p.count >= maxd) begin
               q.err = 1'b1;
            end else begin
               q.count = p.count + 4'd1;
               unique case (p.phase)
                  isoep_pkg::PH_YEAR:   q.year   = 14'(p.year * 14'd10 + 14'(dv));
                  isoep_pkg::PH_MONTH:  q.month  = mul10(p.month, dv);
                  isoep_pkg::PH_DAY:    q.day    = mul10(p.day, dv);
                  isoep_pkg::PH_HOUR:   q.hour   = mul10(p.hour, dv);
                  isoep_pkg::PH_MINUTE: q.minute = mul10(p.minute, dv);
                  isoep_pkg::PH_SECOND: q.second = mul10(p.second, dv);
                  default:              q.count  = p.count + 4'd1;
               endcase
            end
         end else begin
            unique case (p.phase)
               isoep_pkg::PH_YEAR: begin
                  if (c == isoep_pkg::CHAR_DASH && p.count != 4'd0 && p.year != 14'd0) begin
                     q.phase = isoep_pkg::PH_MONTH;
                     q.count = 4'd0;
                  end else begin
                     q.err = 1'b1;
                  end
               end
               isoep_pkg::PH_MONTH: begin
                  if (c == isoep_pkg::CHAR_DASH && p.count != 4'd0 && p.month != 7'd0) begin
                     q.phase = isoep_pkg::PH_DAY;
                     q.count = 4'd0;
                  end else begin
                     q.err = 1'b1;
                  end
               end
               isoep_pkg::PH_DAY: begin
                  if (p.count == 4'd0 || p.day == 7'd0) begin
                     q.err = 1'b1;
                  end else if (c == isoep_pkg::CHAR_T || c == isoep_pkg::CHAR_SPACE) begin
                     q.phase = isoep_pkg::PH_HOUR;
                     q.count = 4'd0;
                  end else begin
                     q = closing(p, c);
                  end
               end
               isoep_pkg::PH_HOUR: begin
                  if (c == isoep_pkg::CHAR_COLON && p.count != 4'd0) begin
                     q.phase = isoep_pkg::PH_MINUTE;
                     q.count = 4'd0;
                  end else begin
                     q.err = 1'b1;
                  end
               end
               isoep_pkg::PH_MINUTE: begin
                  if (p.count == 4'd0) begin
                     q.err = 1'b1;
                  end else if (c == isoep_pkg::CHAR_COLON) begin
                     q.phase = isoep_pkg::PH_SECOND;
                     q.count = 4'd0;
                  end else begin
                     q = closing(p, c);
                  end
               end
               isoep_pkg::PH_SECOND: begin
                  if (p.count == 4'd0) begin
                     q.err = 1'b1;
                  end else if (c == isoep_pkg::CHAR_DOT) begin
                     q.phase = isoep_pkg::PH_FRAC;
                     q.count = 4'd0;
                  end else begin
                     q = closing(p, c);
                  end
               end
               isoep_pkg::PH_FRAC: begin
                  if (p.count == 4'd0) begin
                     q.err = 1'b1;
                  end else begin
                     q = closing(p, c);
                  end
               end
               isoep_pkg::PH_ZSEEN: begin
                  if (c == isoep_pkg::CHAR_NUL) begin
                     q.ended = 1'b1;
                  end else begin
                     q.err = 1'b1;
                  end
               end
               default: q.err = 1'b1;
            endcase
         end
      end
      return q;
   endfunction

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // A text without its own zero byte ends as if one followed the last beat.
   assign after_char = feed(state_ff, req_tdata);
   assign after_end  = feed(after_char, isoep_pkg::CHAR_NUL);

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         if (req_tlast) begin
            state_in = '0;
         end else begin
            state_in = after_char;
         end
      end
   end

   assign q_push       = accept && req_tlast;
   assign q_rec.year   = after_end.year;
   assign q_rec.month  = after_end.month;
   assign q_rec.day    = after_end.day;
   assign q_rec.hour   = after_end.hour;
   assign q_rec.minute = after_end.minute;
   assign q_rec.second = after_end.second;
   assign q_rec.err    = after_end.err;
   assign q_rec.ended  = after_end.ended;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/isoep_queue.sv
module isoep_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  isoep_pkg::rec_type  push_rec,
   input  logic                pop,
   output isoep_pkg::rec_type  head_rec,
   output logic                full,
   output logic                empty
);

   isoep_pkg::rec_type  entry_ff [isoep_pkg::QUEUE_DEPTH];
   isoep_pkg::qptr_type wr_ptr_ff;
   isoep_pkg::qptr_type wr_ptr_in;
   isoep_pkg::qptr_type rd_ptr_ff;
   isoep_pkg::qptr_type rd_ptr_in;
   isoep_pkg::qcnt_type count_ff;
   isoep_pkg::qcnt_type count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == isoep_pkg::qcnt_type'(isoep_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_rec = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = isoep_pkg::qptr_type'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = isoep_pkg::qptr_type'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = isoep_pkg::qcnt_type'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = isoep_pkg::qcnt_type'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

>>> sv/isoep_back.sv
module isoep_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  isoep_pkg::rec_type  q_head,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [55:0]         rsp_tdata,   // epoch_ms[48:0], zero padding
   output logic                rsp_tuser    // valid_res
);

   isoep_pkg::back_state_type state_ff;
   isoep_pkg::back_state_type state_in;

   isoep_pkg::rec_type rec_ff;
   logic [5:0]         qy_ff;
   logic [5:0]         qy_in;
   logic [8:0]         ry_ff;
   logic [8:0]         ry_in;
   logic               ok_ff;
   logic               ok_in;
   logic [13:0]        yy_ff;
   logic [13:0]        yy_in;
   logic [5:0]         era_ff;
   logic [5:0]         era_in;
   logic [8:0]         yoe_ff;
   logic [8:0]         yoe_in;
   logic [17:0]        doe_ff;
   logic [17:0]        doe_in;
   logic signed [23:0] days_ff;
   logic signed [23:0] days_in;
   logic signed [28:0] hrs_ff;
   logic signed [28:0] hrs_in;
   logic signed [33:0] mins_ff;
   logic signed [33:0] mins_in;
   logic [48:0]        ms_ff;
   logic [48:0]        ms_in;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        rsp_ok_ff;
   logic [48:0] rsp_ms_ff;

   logic        out_free;
   logic        load_out;

   logic [26:0] y_prod;
   logic [26:0] yy_prod;
   logic [18:0] ry_prod;
   logic [2:0]  ry_q100;
   logic [6:0]  ry_r100;
   logic        leap;
   logic [18:0] yoe_prod;
   logic [2:0]  yoe_q100;
   logic [3:0]  mp;
   logic [21:0] era_days;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         isoep_pkg::B_IDLE:  if (!q_empty) state_in = isoep_pkg::B_LEAP0;
         isoep_pkg::B_LEAP0: state_in = isoep_pkg::B_LEAP1;
         isoep_pkg::B_LEAP1: state_in = isoep_pkg::B_CHECK;
         isoep_pkg::B_CHECK: state_in = ok_in ? isoep_pkg::B_ERA : isoep_pkg::B_OUT;
         isoep_pkg::B_ERA:   state_in = isoep_pkg::B_YOE;
         isoep_pkg::B_YOE:   state_in = isoep_pkg::B_DOE;
         isoep_pkg::B_DOE:   state_in = isoep_pkg::B_DAYS;
         isoep_pkg::B_DAYS:  state_in = isoep_pkg::B_HRS;
         isoep_pkg::B_HRS:   state_in = isoep_pkg::B_MIN;
         isoep_pkg::B_MIN:   state_in = isoep_pkg::B_MS;
         isoep_pkg::B_MS:    state_in = isoep_pkg::B_OUT;
         isoep_pkg::B_OUT:   if (out_free) state_in = isoep_pkg::B_IDLE;
         default:            state_in = isoep_pkg::B_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      q_pop    = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         isoep_pkg::B_IDLE: q_pop    = !q_empty;
         isoep_pkg::B_OUT:  load_out = out_free;
         default: begin
            q_pop    = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   // Division by 400 and by 100 is done by multiplying with a scaled reciprocal;
   // the operands are small enough that the truncated product is exact.
   always_comb begin
      y_prod   = 27'(rec_ff.year) * 27'd5243;
      qy_in    = y_prod[26:21];
      ry_in    = 9'(rec_ff.year - 14'(qy_ff) * 14'd400);

      ry_prod  = 19'(ry_ff) * 19'd656;
      ry_q100  = ry_prod[18:16];
      ry_r100  = 7'(ry_ff - 9'(ry_q100) * 9'd100);
      leap     = ((rec_ff.year[1:0] == 2'b00) && (ry_r100 != 7'd0)) || (ry_ff == 9'd0);
      ok_in    = !rec_ff.err && rec_ff.ended &&
                 (rec_ff.year != 14'd0) && (rec_ff.year <= isoep_pkg::YEAR_MAX) &&
                 (rec_ff.month != 7'd0) && (rec_ff.month <= 7'd12) &&
                 (rec_ff.day != 7'd0) &&
                 (rec_ff.day <= 7'(isoep_pkg::month_days(rec_ff.month, leap))) &&
                 (rec_ff.hour <= 7'd23) && (rec_ff.minute <= 7'd59) &&
                 (rec_ff.second <= 7'd59);
      yy_in    = (rec_ff.month <= 7'd2) ? 14'(rec_ff.year - 14'd1) : rec_ff.year;

      yy_prod  = 27'(yy_ff) * 27'd5243;
      era_in   = yy_prod[26:21];
      yoe_in   = 9'(yy_ff - 14'(era_ff) * 14'd400);

      yoe_prod = 19'(yoe_ff) * 19'd656;
      yoe_q100 = yoe_prod[18:16];
      mp       = (rec_ff.month > 7'd2) ? 4'(rec_ff.month - 7'd3) : 4'(rec_ff.month + 7'd9);
      doe_in   = 18'(yoe_ff) * 18'd365 + 18'(yoe_ff[8:2]) - 18'(yoe_q100)
                 + 18'(isoep_pkg::doy_base(mp)) + 18'(rec_ff.day) - 18'd1;

      era_days = 22'(era_ff) * 22'd146097;
      days_in  = 24'(era_days) + 24'(doe_ff) - 24'd719468;
      hrs_in   = 29'(days_ff) * 29'd24 + 29'(rec_ff.hour);
      mins_in  = 34'(hrs_ff) * 34'd60 + 34'(rec_ff.minute);
      ms_in    = 49'(mins_ff) * 49'd60000 + 49'(rec_ff.second) * 49'd1000;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isoep_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rec_ff <= q_head;
      end
      if (state_ff == isoep_pkg::B_LEAP0) begin
         qy_ff <= qy_in;
      end
      if (state_ff == isoep_pkg::B_LEAP1) begin
         ry_ff <= ry_in;
      end
      if (state_ff == isoep_pkg::B_CHECK) begin
         ok_ff <= ok_in;
         yy_ff <= yy_in;
      end
      if (state_ff == isoep_pkg::B_ERA) begin
         era_ff <= era_in;
      end
      if (state_ff == isoep_pkg::B_YOE) begin
         yoe_ff <= yoe_in;
      end
      if (state_ff == isoep_pkg::B_DOE) begin
         doe_ff <= doe_in;
      end
      if (state_ff == isoep_pkg::B_DAYS) begin
         days_ff <= days_in;
      end
      if (state_ff == isoep_pkg::B_HRS) begin
         hrs_ff <= hrs_in;
      end
      if (state_ff == isoep_pkg::B_MIN) begin
         mins_ff <= mins_in;
      end
      if (state_ff == isoep_pkg::B_MS) begin
         ms_ff <= ms_in;
      end
      if (load_out) begin
         rsp_ok_ff <= ok_ff;
         rsp_ms_ff <= ok_ff ? ms_ff : 49'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {7'd0, rsp_ms_ff};

endmodule

>>> sv/iso_timestamp_to_epoch_ms.sv
// Character beats are taken one per cycle while the two-entry text queue has room.
// A well-formed text runs through the leap-year, check and date states of the date
// sequencer; a rejected text goes from the check straight to output. The sequencer
// takes one text at a time, which sets the rate for short texts.
// Synchronous reset returns the parser to the year field, empties the queue and
// drops any result not yet taken.
module iso_timestamp_to_epoch_ms (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // char_byte[7:0]
   input  logic        req_tlast,    // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // epoch_ms[48:0], zero padding
   output logic        rsp_tuser     // valid_res
);

   logic               q_push;
   isoep_pkg::rec_type q_rec;
   logic               q_pop;
   isoep_pkg::rec_type q_head;
   logic               q_full;
   logic               q_empty;

   isoep_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_rec      (q_rec)
   );

   isoep_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_rec),
      .pop      (q_pop),
      .head_rec (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   isoep_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
